FILE: hdl/u8u16_pkg.sv
// shared types and constants for the utf-8 to utf-16 decoder
`default_nettype none

package u8u16_pkg;

    // value widths
    localparam int UNIT_W = 21;
    localparam int REPL_W = 3;

    // descriptor queue size
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // sequence lengths held in the pending-sequence register
    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    // unicode constants
    localparam logic [UNIT_W-1:0] REPL_CHAR    = 21'h00FFFD;
    localparam logic [UNIT_W-1:0] MAX_SCALAR   = 21'h10FFFF;
    localparam logic [UNIT_W-1:0] SUPP_BASE    = 21'h010000;
    localparam logic [UNIT_W-1:0] MIN_THREE    = 21'h000800;
    localparam logic [UNIT_W-1:0] MIN_TWO      = 21'h000080;
    localparam logic [UNIT_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [UNIT_W-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [UNIT_W-1:0] HIGH_SURR    = 21'h00D800;
    localparam logic [UNIT_W-1:0] LOW_SURR     = 21'h00DC00;

    // work for the back end from one input byte: replacements first,
    // then an optional scalar, split into a surrogate pair when pair is set
    typedef struct packed {
        logic [REPL_W-1:0] repl_cnt;
        logic              has_cp;
        logic              pair;
        logic [UNIT_W-1:0] cp;
    } u8u16_desc_t;

endpackage : u8u16_pkg

`default_nettype wire

FILE: hdl/u8u16_front.sv
// front end: takes bytes, tracks the pending sequence, builds descriptors
`default_nettype none

module u8u16_front
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    output      logic        push,
    output      u8u16_desc_t desc
);

    logic              mode_reg;
    logic [2:0]        total_reg, total_next;
    logic [2:0]        seen_reg, seen_next;
    logic [UNIT_W-1:0] pv_reg, pv_next;

    logic              pending;
    logic              is_cont;
    logic [UNIT_W-1:0] acc;
    logic [2:0]        seen_inc;
    logic [REPL_W-1:0] lead_repl;
    logic              bad;

    // decode of one byte against the pending sequence
    always_comb
    begin
        pending   = (total_reg != SEQ_NONE);
        is_cont   = (in_byte[7:6] == 2'b10);
        acc       = {pv_reg[UNIT_W-7:0], in_byte[5:0]};
        seen_inc  = seen_reg + 3'd1;
        lead_repl = pending ? seen_reg : 3'd0;

        case (total_reg)
            SEQ_TWO:   bad = (acc < MIN_TWO);
            SEQ_THREE: bad = (acc < MIN_THREE) || ((acc >= SURR_LO) && (acc <= SURR_HI));
            default:   bad = (acc < SUPP_BASE) || (acc > MAX_SCALAR);
        endcase

        desc       = '0;
        total_next = total_reg;
        seen_next  = seen_reg;
        pv_next    = pv_reg;

        if (pending && is_cont)
        begin
            if (seen_inc >= total_reg)
            begin
                // sequence complete
                total_next = SEQ_NONE;
                seen_next  = 3'd0;
                pv_next    = '0;
                if (bad)
                begin
                    desc.repl_cnt = 3'd1;
                end
                else
                begin
                    desc.has_cp = 1'b1;
                    desc.cp     = acc;
                end
            end
            else if (last_byte)
            begin
                // input ends inside a sequence
                desc.repl_cnt = seen_inc;
                total_next    = SEQ_NONE;
                seen_next     = 3'd0;
                pv_next       = '0;
            end
            else
            begin
                seen_next = seen_inc;
                pv_next   = acc;
            end
        end
        else
        begin
            // any broken sequence is flushed, the byte starts over as a lead
            desc.repl_cnt = lead_repl;
            total_next    = SEQ_NONE;
            seen_next     = 3'd0;
            pv_next       = '0;
            if (!in_byte[7])
            begin
                desc.has_cp = 1'b1;
                desc.cp     = {{(UNIT_W-8){1'b0}}, in_byte};
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                total_next = SEQ_TWO;
                seen_next  = 3'd1;
                pv_next    = {{(UNIT_W-5){1'b0}}, in_byte[4:0]};
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                total_next = SEQ_THREE;
                seen_next  = 3'd1;
                pv_next    = {{(UNIT_W-4){1'b0}}, in_byte[3:0]};
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                total_next = SEQ_FOUR;
                seen_next  = 3'd1;
                pv_next    = {{(UNIT_W-3){1'b0}}, in_byte[2:0]};
            end
            else
            begin
                desc.repl_cnt = lead_repl + 3'd1;
            end

            // lead byte that is also the last one
            if (last_byte && (total_next != SEQ_NONE))
            begin
                desc.repl_cnt = lead_repl + 3'd1;
                total_next    = SEQ_NONE;
                seen_next     = 3'd0;
                pv_next       = '0;
            end
        end

        desc.pair = desc.has_cp && !mode_reg && (desc.cp >= SUPP_BASE);
        push      = in_valid && in_ready && ((desc.repl_cnt != 3'd0) || desc.has_cp);
    end

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // pending sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= SEQ_NONE;
            seen_reg  <= 3'd0;
            pv_reg    <= '0;
        end
        else if (in_valid && in_ready)
        begin
            total_reg <= total_next;
            seen_reg  <= seen_next;
            pv_reg    <= pv_next;
        end
    end

endmodule : u8u16_front

`default_nettype wire

FILE: hdl/u8u16_queue.sv
// short descriptor queue between front and back end
`default_nettype none

module u8u16_queue
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire u8u16_desc_t push_desc,
    input  wire logic        pop,
    output      logic        full,
    output      logic        empty,
    output      u8u16_desc_t head
);

    u8u16_desc_t         entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    // status and head of queue
    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule : u8u16_queue

`default_nettype wire

FILE: hdl/u8u16_back.sv
// back end: expands descriptors into result beats, one per cycle while out_ready is high
`default_nettype none

module u8u16_back
    import u8u16_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire u8u16_desc_t       head,
    output      logic              pop,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [UNIT_W-1:0] out_unit,
    output      logic              is_replacement,
    output      logic              run_end
);

    logic              out_valid_reg;
    logic [UNIT_W-1:0] out_unit_reg, out_unit_next;
    logic              is_repl_reg, is_repl_next;
    logic              run_end_reg, run_end_next;
    logic [1:0]        step_reg;

    logic              load;
    logic [2:0]        idx;
    logic [2:0]        total;
    logic [UNIT_W-1:0] supp;

    // pick the result at the current step of the head descriptor
    always_comb
    begin
        load  = !empty && (!out_valid_reg || out_ready);
        idx   = {1'b0, step_reg};
        total = head.repl_cnt + {2'b00, head.has_cp} + {2'b00, head.pair};
        supp  = head.cp - SUPP_BASE;

        if (idx < head.repl_cnt)
        begin
            out_unit_next = REPL_CHAR;
            is_repl_next  = 1'b1;
        end
        else if (head.pair && (idx == head.repl_cnt))
        begin
            out_unit_next = HIGH_SURR + {{(UNIT_W-10){1'b0}}, supp[19:10]};
            is_repl_next  = 1'b0;
        end
        else if (head.pair)
        begin
            out_unit_next = LOW_SURR + {{(UNIT_W-10){1'b0}}, supp[9:0]};
            is_repl_next  = 1'b0;
        end
        else
        begin
            out_unit_next = head.cp;
            is_repl_next  = 1'b0;
        end

        run_end_next = ((idx + 3'd1) == total);
        pop          = load && run_end_next;
    end

    // step within the head descriptor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg <= run_end_next ? 2'd0 : step_reg + 2'd1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_unit_reg <= out_unit_next;
            is_repl_reg  <= is_repl_next;
            run_end_reg  <= run_end_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_unit       = out_unit_reg;
    assign is_replacement = is_repl_reg;
    assign run_end        = run_end_reg;

endmodule : u8u16_back

`default_nettype wire

FILE: hdl/utf8_to_utf16_decoder_unit.sv
// Top level of the utf-8 to utf-16 decoder.
// Input channel (in_valid/in_ready): one utf-8 byte per beat, last_byte marks
// the end of the stream and flushes an unfinished sequence as replacements.
// Output channel (out_valid/out_ready): one result per beat, a utf-16 code
// unit or, with output_mode set, a whole code point; is_replacement flags
// U+FFFD from a decoding error, run_end marks the last beat of one input byte.
// Config: cfg_we/cfg_wdata write output_mode; write it only while idle.
// Throughput: one byte per cycle in while the queue has room, one result beat
// per cycle out while out_ready is high; a byte with n results (n up to four)
// takes n beats, one with none pushes nothing. The single output register
// sets the rate. Each byte's descriptor is queued, then loaded to the output.
// A four-entry descriptor queue parts the byte decoder from the output
// expander, so input keeps flowing while the receiver stalls until the queue
// fills; in_ready then drops and the output holds its beat steady.
// Reset clears the pending sequence, the queue, the output and the mode (0).
`default_nettype none

module utf8_to_utf16_decoder_unit
    import u8u16_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              last_byte,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic [UNIT_W-1:0] out_unit,
    output      logic              is_replacement,
    output      logic              run_end
);

    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    u8u16_desc_t push_desc;
    u8u16_desc_t head;

    // accept while the queue has room
    assign in_ready = !full;

    // byte decoder
    u8u16_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .push      (push),
        .desc      (push_desc)
    );

    // descriptor queue
    u8u16_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    // result expander
    u8u16_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (empty),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_unit       (out_unit),
        .is_replacement (is_replacement),
        .run_end        (run_end)
    );

endmodule : utf8_to_utf16_decoder_unit

`default_nettype wire
